/* design/assert_macros.svh */
// Assertion macros used by the top-level design file to check its own behavior.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising clock edge outside reset.
`define ASSERT_HOLDS(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("design check failed");

// Condition that must never be true at a rising clock edge outside reset.
`define ASSERT_NEVER(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error("forbidden condition seen");

`endif

/* design/clti_pkg.sv */
// Shared types and constants of the clamped linear table interpolator.
`timescale 1ns / 1ps

package clti_pkg;

   localparam int MAX_POINTS = 32;
   localparam int IDX_W      = $clog2(MAX_POINTS);
   localparam int CNT_W      = 6;
   localparam int DATA_W     = 32;

   localparam logic [0:0] ACTION_WRITE = 1'b0;
   localparam logic [0:0] ACTION_QUERY = 1'b1;

   localparam logic [1:0] STATUS_INTERP      = 2'd0;
   localparam logic [1:0] STATUS_CLAMP_BELOW = 2'd1;
   localparam logic [1:0] STATUS_CLAMP_ABOVE = 2'd2;

   localparam logic [CNT_W-1:0] POINT_COUNT_RESET = CNT_W'(1);

   typedef struct packed {
      logic [DATA_W-1:0] freq;
      logic [DATA_W-1:0] amp;
   } entry_type;

endpackage

/* design/clamped_linear_table_interp_top.sv */
// Top level: breakpoint table memory, interval scan and serial divider.
// A write leaves busy low. A query holds busy through the check below, the check above
// and the single-point case, the scan reads and, unless the interval is degenerate, the
// multiply and the divider. Its strobe rises as busy drops, when the next query can
// already be taken. The receiver cannot stall. Synchronous reset clears control, count 1.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module clamped_linear_table_interp_top (
   input  logic                              clock,
   input  logic                              reset,
   // Input channel: an item transfers at an edge with start high and busy low.
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_action,
   input  logic [clti_pkg::IDX_W-1:0]        req_entry_index,
   input  logic [clti_pkg::DATA_W-1:0]       req_entry_freq,
   input  logic [clti_pkg::DATA_W-1:0]       req_entry_amp,
   input  logic [clti_pkg::DATA_W-1:0]       req_query_freq,
   // Result channel: one-cycle strobe, no back pressure.
   output logic                              rsp_valid,
   output logic [clti_pkg::DATA_W-1:0]       rsp_result_amp,
   output logic [1:0]                        rsp_clamp_status,
   // Configuration: the point_count register.
   input  logic                              csr_wr_en,
   input  logic [clti_pkg::CNT_W-1:0]        csr_wr_data
);

   // The query sequencer. FIRST and LAST check the clamps against entry 0 and the last
   // entry in use, SCAN walks the table one entry per cycle to find the bracketing
   // interval, MUL forms the scaled numerator and DIV produces one quotient bit per cycle.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FIRST,
      ST_LAST,
      ST_SCAN,
      ST_MUL,
      ST_DIV,
      ST_FIN
   } state_type;

   state_type                         state_ff;

   logic [clti_pkg::CNT_W-1:0]        point_count_ff;
   logic [clti_pkg::CNT_W-1:0]        n_ff;
   logic [clti_pkg::DATA_W-1:0]       x_ff;
   clti_pkg::entry_type               lo_ff;
   logic [clti_pkg::IDX_W-1:0]        idx_ff;
   logic [clti_pkg::DATA_W-1:0]       num_ff;
   logic [clti_pkg::DATA_W-1:0]       den_ff;
   logic [clti_pkg::DATA_W-1:0]       dy_ff;
   logic                              rising_ff;
   logic [clti_pkg::DATA_W-1:0]       rem_ff;
   logic [clti_pkg::DATA_W-1:0]       qsh_ff;
   logic [clti_pkg::IDX_W-1:0]        cnt_ff;

   logic                              rsp_valid_ff;
   logic [clti_pkg::DATA_W-1:0]       rsp_result_amp_ff;
   logic [1:0]                        rsp_clamp_status_ff;

   // Breakpoint table: one write port, one read port, read data registered.
   clti_pkg::entry_type               table_mem [clti_pkg::MAX_POINTS];
   clti_pkg::entry_type               rd_data_ff;
   logic [clti_pkg::IDX_W-1:0]        rd_addr;
   logic                              wr_en;

   logic                              accept;
   logic [clti_pkg::CNT_W-1:0]        n_used;
   logic [clti_pkg::IDX_W-1:0]        last_idx;
   logic [clti_pkg::CNT_W-1:0]        next_idx_wide;
   logic                              scan_advance;
   logic                              degenerate;
   logic [2*clti_pkg::DATA_W-1:0]     product;
   logic [clti_pkg::DATA_W:0]         div_trial;
   logic [clti_pkg::DATA_W:0]         div_diff;
   logic                              div_ge;

   assign accept = start && !busy;
   assign busy   = (state_ff != ST_IDLE);

   // Writes only land while the sequencer is idle, so a query never reads an entry that is
   // being written in the same cycle; busy is the interlock.
   assign wr_en  = accept && (req_action == clti_pkg::ACTION_WRITE);

   // A count of zero acts as one and a count above the table depth acts as the full table.
   always_comb begin
      if (point_count_ff == '0) begin
         n_used = clti_pkg::CNT_W'(1);
      end else if (point_count_ff > clti_pkg::CNT_W'(clti_pkg::MAX_POINTS)) begin
         n_used = clti_pkg::CNT_W'(clti_pkg::MAX_POINTS);
      end else begin
         n_used = point_count_ff;
      end
   end

   assign last_idx = clti_pkg::IDX_W'(n_ff - clti_pkg::CNT_W'(1));

   // In SCAN, rd_data_ff holds entry idx_ff, the right end of the candidate interval. The
   // scan moves on while a further interval exists and the query lies past that entry.
   assign next_idx_wide = clti_pkg::CNT_W'(idx_ff) + clti_pkg::CNT_W'(1);
   assign scan_advance  = (next_idx_wide < n_ff) && (x_ff > rd_data_ff.freq);
   assign degenerate    = (x_ff <= lo_ff.freq) || (rd_data_ff.freq <= lo_ff.freq);

   always_comb begin
      unique case (state_ff)
         ST_IDLE:  rd_addr = '0;
         ST_FIRST: rd_addr = last_idx;
         ST_LAST:  rd_addr = clti_pkg::IDX_W'(1);
         ST_SCAN:  rd_addr = next_idx_wide[clti_pkg::IDX_W-1:0];
         default:  rd_addr = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[req_entry_index] <= '{freq: req_entry_freq, amp: req_entry_amp};
      end
      rd_data_ff <= table_mem[rd_addr];
   end

   // The numerator (x - xlo) never exceeds the width (xhi - xlo), so the product's upper
   // word is already below the divisor and 32 restoring steps give the whole quotient.
   assign product   = 64'(num_ff) * 64'(dy_ff);
   assign div_trial = {rem_ff, qsh_ff[clti_pkg::DATA_W-1]};
   assign div_diff  = div_trial - {1'b0, den_ff};
   assign div_ge    = (div_trial >= {1'b0, den_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         point_count_ff <= clti_pkg::POINT_COUNT_RESET;
      end else begin
         rsp_valid_ff <= 1'b0;
         if (csr_wr_en) begin
            point_count_ff <= csr_wr_data;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept && (req_action == clti_pkg::ACTION_QUERY)) begin
                  x_ff     <= req_query_freq;
                  n_ff     <= n_used;
                  state_ff <= ST_FIRST;
               end
            end
            ST_FIRST: begin
               lo_ff <= rd_data_ff;
               if (x_ff < rd_data_ff.freq) begin
                  rsp_valid_ff        <= 1'b1;
                  rsp_result_amp_ff   <= rd_data_ff.amp;
                  rsp_clamp_status_ff <= clti_pkg::STATUS_CLAMP_BELOW;
                  state_ff            <= ST_IDLE;
               end else begin
                  state_ff <= ST_LAST;
               end
            end
            ST_LAST: begin
               if (rd_data_ff.freq < x_ff) begin
                  rsp_valid_ff        <= 1'b1;
                  rsp_result_amp_ff   <= rd_data_ff.amp;
                  rsp_clamp_status_ff <= clti_pkg::STATUS_CLAMP_ABOVE;
                  state_ff            <= ST_IDLE;
               end else if (n_ff < clti_pkg::CNT_W'(2)) begin
                  rsp_valid_ff        <= 1'b1;
                  rsp_result_amp_ff   <= lo_ff.amp;
                  rsp_clamp_status_ff <= clti_pkg::STATUS_INTERP;
                  state_ff            <= ST_IDLE;
               end else begin
                  idx_ff   <= clti_pkg::IDX_W'(1);
                  state_ff <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               if (scan_advance) begin
                  lo_ff  <= rd_data_ff;
                  idx_ff <= next_idx_wide[clti_pkg::IDX_W-1:0];
               end else if (degenerate) begin
                  rsp_valid_ff        <= 1'b1;
                  rsp_result_amp_ff   <= lo_ff.amp;
                  rsp_clamp_status_ff <= clti_pkg::STATUS_INTERP;
                  state_ff            <= ST_IDLE;
               end else begin
                  num_ff    <= x_ff - lo_ff.freq;
                  den_ff    <= rd_data_ff.freq - lo_ff.freq;
                  rising_ff <= (rd_data_ff.amp >= lo_ff.amp);
                  dy_ff     <= (rd_data_ff.amp >= lo_ff.amp) ?
                               (rd_data_ff.amp - lo_ff.amp) :
                               (lo_ff.amp - rd_data_ff.amp);
                  state_ff  <= ST_MUL;
               end
            end
            ST_MUL: begin
               rem_ff   <= product[2*clti_pkg::DATA_W-1:clti_pkg::DATA_W];
               qsh_ff   <= product[clti_pkg::DATA_W-1:0];
               cnt_ff   <= '0;
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               rem_ff <= div_ge ? div_diff[clti_pkg::DATA_W-1:0]
                                : div_trial[clti_pkg::DATA_W-1:0];
               qsh_ff <= {qsh_ff[clti_pkg::DATA_W-2:0], div_ge};
               cnt_ff <= cnt_ff + clti_pkg::IDX_W'(1);
               if (cnt_ff == clti_pkg::IDX_W'(clti_pkg::DATA_W - 1)) begin
                  state_ff <= ST_FIN;
               end
            end
            ST_FIN: begin
               // The quotient never exceeds |yhi - ylo|, so the result stays between the
               // two amplifications and neither sum wraps.
               rsp_valid_ff        <= 1'b1;
               rsp_result_amp_ff   <= rising_ff ? (lo_ff.amp + qsh_ff) : (lo_ff.amp - qsh_ff);
               rsp_clamp_status_ff <= clti_pkg::STATUS_INTERP;
               state_ff            <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_amp   = rsp_result_amp_ff;
   assign rsp_clamp_status = rsp_clamp_status_ff;

   // Every path that raises the strobe returns to idle, so a result lasts one cycle.
   `ASSERT_HOLDS(a_strobe_single, rsp_valid |=> !rsp_valid)
   // A result is only given as the sequencer goes back to idle.
   `ASSERT_HOLDS(a_strobe_idle, rsp_valid |-> !busy)
   // An accepted query occupies the block; an accepted write does not.
   `ASSERT_HOLDS(a_query_busy, (accept && (req_action == clti_pkg::ACTION_QUERY)) |=> busy)
   `ASSERT_HOLDS(a_write_free, (accept && (req_action == clti_pkg::ACTION_WRITE)) |=> !busy)
   // The divider only runs on an interval of nonzero width.
   `ASSERT_NEVER(a_div_nonzero, (state_ff == ST_DIV) && (den_ff == '0))

endmodule

/* tb/tb_clamped_linear_table_interp_top.sv */
// Self-checking testbench for the clamped linear table interpolator top level.
`timescale 1ns / 1ps

module tb_clamped_linear_table_interp_top;

   // One expected query answer: amplification and the clamp that applied.
   typedef struct packed {
      logic [clti_pkg::DATA_W-1:0] amp;
      logic [1:0]                  status;
   } interp_answer_type;

   // Scoreboard with its own copy of the breakpoint table and point_count.
   // Every write transfer updates the copy; every query transfer queues the
   // answer that the block must return.
   class interp_scoreboard_type;
      logic [clti_pkg::DATA_W-1:0] freq_table [clti_pkg::MAX_POINTS];
      logic [clti_pkg::DATA_W-1:0] amp_table [clti_pkg::MAX_POINTS];
      bit [clti_pkg::MAX_POINTS-1:0] loaded;
      logic [clti_pkg::CNT_W-1:0] point_count;
      interp_answer_type answers_due [$];
      int failures;

      function new();
         loaded = '0;
         point_count = clti_pkg::POINT_COUNT_RESET;
         failures = 0;
      endfunction

      function void set_point_count(logic [clti_pkg::CNT_W-1:0] value);
         point_count = value;
      endfunction

      // Zero counts as one point, anything past the table counts as all of it.
      function int used_points();
         int n;
         n = point_count;
         if (n < 1) n = 1;
         if (n > clti_pkg::MAX_POINTS) n = clti_pkg::MAX_POINTS;
         return n;
      endfunction

      // True when every entry that a query could read has been written.
      function bit table_ready();
         bit ready;
         ready = 1'b1;
         for (int k = 0; k < used_points(); k++) begin
            if (!loaded[k]) ready = 1'b0;
         end
         return ready;
      endfunction

      function int pending();
         return answers_due.size();
      endfunction

      function interp_answer_type amplification_at(logic [clti_pkg::DATA_W-1:0] x);
         interp_answer_type ans;
         int n;
         int seg;
         logic [clti_pkg::DATA_W-1:0] xlo, xhi, ylo, yhi, xcap;
         logic [63:0] width, offset, delta;
         n = used_points();
         ans.status = clti_pkg::STATUS_INTERP;
         if (x < freq_table[0]) begin
            ans.amp = amp_table[0];
            ans.status = clti_pkg::STATUS_CLAMP_BELOW;
         end else if (freq_table[n-1] < x) begin
            ans.amp = amp_table[n-1];
            ans.status = clti_pkg::STATUS_CLAMP_ABOVE;
         end else if (n < 2) begin
            ans.amp = amp_table[0];
         end else begin
            // First interval whose right edge is at or above x, last one at most.
            seg = 0;
            while (seg + 2 < n && x > freq_table[seg+1]) seg++;
            xlo = freq_table[seg];
            xhi = freq_table[seg+1];
            ylo = amp_table[seg];
            yhi = amp_table[seg+1];
            if (x <= xlo || xhi <= xlo) begin
               ans.amp = ylo;
            end else begin
               xcap = (x > xhi) ? xhi : x;
               width = 64'(xhi) - 64'(xlo);
               offset = 64'(xcap) - 64'(xlo);
               // Truncation toward the left value keeps the result in range.
               if (yhi >= ylo) begin
                  delta = (offset * 64'(yhi - ylo)) / width;
                  ans.amp = ylo + delta[clti_pkg::DATA_W-1:0];
               end else begin
                  delta = (offset * 64'(ylo - yhi)) / width;
                  ans.amp = ylo - delta[clti_pkg::DATA_W-1:0];
               end
            end
         end
         return ans;
      endfunction

      function void note_input(logic action, logic [clti_pkg::IDX_W-1:0] index,
                               logic [clti_pkg::DATA_W-1:0] freq,
                               logic [clti_pkg::DATA_W-1:0] amp,
                               logic [clti_pkg::DATA_W-1:0] query_freq);
         if (action == clti_pkg::ACTION_WRITE) begin
            freq_table[index] = freq;
            amp_table[index] = amp;
            loaded[index] = 1'b1;
         end else begin
            answers_due.push_back(amplification_at(query_freq));
         end
      endfunction

      task report(string msg);
         $display("[%0t] mismatch: %s", $realtime, msg);
         failures++;
      endtask

      task check_result(logic [clti_pkg::DATA_W-1:0] amp, logic [1:0] status);
         interp_answer_type due;
         if (answers_due.size() == 0) begin
            report($sformatf("unexpected result amp=%h status=%0d", amp, status));
         end else begin
            due = answers_due.pop_front();
            if (amp !== due.amp)
               report($sformatf("result_amp %h, expected %h", amp, due.amp));
            if (status !== due.status)
               report($sformatf("clamp_status %0d, expected %0d", status, due.status));
         end
      endtask
   endclass

   // Items to send in total, the directed part included.
   localparam int ITEM_GOAL = 1150;
   // Longest query: both clamp checks, a scan through the whole table, the
   // multiply, the divider steps and the finish.
   localparam int SETTLE_CYCLES = 80;

   // All block inputs start at known values.
   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic req_action = clti_pkg::ACTION_WRITE;
   logic [clti_pkg::IDX_W-1:0] req_entry_index = '0;
   logic [clti_pkg::DATA_W-1:0] req_entry_freq = '0;
   logic [clti_pkg::DATA_W-1:0] req_entry_amp = '0;
   logic [clti_pkg::DATA_W-1:0] req_query_freq = '0;
   logic rsp_valid;
   logic [clti_pkg::DATA_W-1:0] rsp_result_amp;
   logic [1:0] rsp_clamp_status;
   logic csr_wr_en = 1'b0;
   logic [clti_pkg::CNT_W-1:0] csr_wr_data = '0;

   interp_scoreboard_type tracker = new();
   int items_sent = 0;
   bit burst_mode = 1'b0;

   always #5 clock = ~clock;

   clamped_linear_table_interp_top dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_action       (req_action),
      .req_entry_index  (req_entry_index),
      .req_entry_freq   (req_entry_freq),
      .req_entry_amp    (req_entry_amp),
      .req_query_freq   (req_query_freq),
      .rsp_valid        (rsp_valid),
      .rsp_result_amp   (rsp_result_amp),
      .rsp_clamp_status (rsp_clamp_status),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   // The result side cannot stall, so every strobe is a completed transfer.
   // Outputs are read right after the edge, before the design's own updates
   // land, so they hold the values that the edge captured.
   always @(posedge clock) begin
      if (!reset && rsp_valid) tracker.check_result(rsp_result_amp, rsp_clamp_status);
   end

   // Hard stop in case the block hangs; well above the slowest legal run.
   initial begin
      #6_000_000;
      $display("FAIL clamped_linear_table_interp_top");
      $finish;
   end

   // Presents one item and holds it until the block takes it. Start is left
   // high so that a following item can go out back to back; a gap lowers it.
   task automatic send_item(logic action, logic [clti_pkg::IDX_W-1:0] index,
                            logic [clti_pkg::DATA_W-1:0] freq,
                            logic [clti_pkg::DATA_W-1:0] amp,
                            logic [clti_pkg::DATA_W-1:0] query_freq);
      req_action <= action;
      req_entry_index <= index;
      req_entry_freq <= freq;
      req_entry_amp <= amp;
      req_query_freq <= query_freq;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      tracker.note_input(action, index, freq, amp, query_freq);
      items_sent++;
   endtask

   task automatic write_entry(int index, logic [clti_pkg::DATA_W-1:0] freq,
                              logic [clti_pkg::DATA_W-1:0] amp);
      send_item(clti_pkg::ACTION_WRITE, clti_pkg::IDX_W'(index), freq, amp, $urandom());
   endtask

   // Entry fields of a query carry junk so that the block must ignore them.
   task automatic query_at(logic [clti_pkg::DATA_W-1:0] x);
      send_item(clti_pkg::ACTION_QUERY,
                clti_pkg::IDX_W'($urandom_range(0, clti_pkg::MAX_POINTS - 1)),
                $urandom(), $urandom(), x);
   endtask

   // Sender gap after a transfer: mostly none or short, now and then long.
   task automatic sender_gap();
      int r;
      int cycles;
      r = $urandom_range(0, 99);
      if (burst_mode || r < 60) cycles = 0;
      else if (r < 90) cycles = $urandom_range(1, 3);
      else cycles = $urandom_range(10, 60);
      if (cycles > 0) begin
         start <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // Holds the sender until every queued answer has come back, then waits
   // out the latency so that a write-only tail cannot still be in flight.
   task automatic wait_for_answers(int settle);
      if (tracker.pending() == 0 && settle == 0) return;
      start <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_point_count(logic [clti_pkg::CNT_W-1:0] value);
      wait_for_answers(SETTLE_CYCLES);
      csr_wr_data <= value;
      csr_wr_en <= 1'b1;
      @(posedge clock);
      tracker.set_point_count(value);
      csr_wr_en <= 1'b0;
   endtask

   // Loads entries 0..n-1. Style 0 is a sorted table across the full range,
   // style 1 a sorted narrow table with repeated frequencies, style 2 noise.
   task automatic load_table(int n, int style);
      logic [clti_pkg::DATA_W-1:0] freqs [$];
      logic [clti_pkg::DATA_W-1:0] base;
      base = $urandom_range(32'hFFFF_0000, 0);
      for (int k = 0; k < n; k++) begin
         if (style == 1) freqs.push_back(base + $urandom_range(0, 3 * n));
         else freqs.push_back($urandom());
      end
      if (style != 2) freqs.sort();
      for (int k = 0; k < n; k++) begin
         write_entry(k, freqs[k], $urandom());
         sender_gap();
      end
   endtask

   // Query frequencies aimed mostly inside the table, with exact breakpoints,
   // the neighbors of the ends and raw random values mixed in.
   function automatic logic [clti_pkg::DATA_W-1:0] pick_query_freq();
      int n;
      int r;
      int seg;
      n = tracker.used_points();
      r = $urandom_range(0, 99);
      seg = $urandom_range(0, n - 1);
      if (r < 55 && n >= 2) begin
         seg = $urandom_range(0, n - 2);
         return $urandom_range(tracker.freq_table[seg], tracker.freq_table[seg+1]);
      end
      if (r < 72) return tracker.freq_table[seg];
      if (r < 78) return tracker.freq_table[0] - 1;
      if (r < 84) return tracker.freq_table[n-1] + 1;
      if (r < 92) return $urandom();
      if (r < 96) return '0;
      return '1;
   endfunction

   initial begin
      int plan [6];
      int phase;
      int count;
      int style;
      int run_len;

      plan = '{32, 2, 0, 63, 1, 33};
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed part. With the reset count of one point: below, exactly on
      // and above the single breakpoint.
      write_entry(0, 32'h0010_0000, 32'hFFFF_FFFF);
      query_at(32'h0000_0000);
      query_at(32'h0010_0000);
      query_at(32'hFFFF_FFFF);

      // Five points: a falling interval across nearly the full amplitude
      // range, a zero-width interval, a rising interval from zero to the
      // maximum, and a last point that is out of frequency order.
      write_entry(1, 32'h0020_0000, 32'h0000_0001);
      write_entry(2, 32'h0020_0000, 32'h0000_0000);
      write_entry(3, 32'h0030_0000, 32'hFFFF_FFFF);
      write_entry(4, 32'h0028_0000, 32'h0001_0000);
      write_point_count(clti_pkg::CNT_W'(5));
      query_at(32'h0010_0000);   // exactly the first point, not clamped
      query_at(32'h0017_3333);   // inside the falling interval
      query_at(32'h0020_0000);   // right edge of the first interval
      query_at(32'h0024_0000);   // past the zero-width pair into the rising one
      query_at(32'h0028_0000);   // exactly the last point, not clamped
      query_at(32'h0028_0001);   // just above the last point
      query_at(32'h000F_FFFF);   // just below the first point

      // Two points sharing one frequency: the query on it returns the left value.
      write_entry(1, 32'h0010_0000, 32'h0000_0000);
      write_point_count(clti_pkg::CNT_W'(2));
      query_at(32'h0010_0000);
      write_entry(0, 32'h0000_0000, 32'h0000_0000);
      write_entry(1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      query_at(32'h8000_0000);
      query_at(32'hFFFF_FFFF);

      // Random phases. Each sets point_count while the block is idle, loads
      // the points in use, then mixes queries with occasional rewrites.
      phase = 0;
      while (items_sent < ITEM_GOAL) begin
         if (phase < 6) count = plan[phase];
         else if ($urandom_range(0, 99) < 80) count = $urandom_range(2, clti_pkg::MAX_POINTS);
         else count = $urandom_range(0, 2 ** clti_pkg::CNT_W - 1);
         write_point_count(clti_pkg::CNT_W'(count));
         burst_mode = ($urandom_range(0, 3) == 0);

         style = $urandom_range(0, 9);
         style = (style < 6) ? 0 : (style < 9) ? 1 : 2;
         load_table(tracker.used_points(), style);

         run_len = $urandom_range(20, 120);
         for (int k = 0; k < run_len && items_sent < ITEM_GOAL; k++) begin
            if ($urandom_range(0, 99) < 12 || !tracker.table_ready())
               write_entry($urandom_range(0, clti_pkg::MAX_POINTS - 1), $urandom(), $urandom());
            else
               query_at(pick_query_freq());
            // Now and then the sender holds off until the block has answered.
            if ($urandom_range(0, 99) == 0) wait_for_answers(0);
            else sender_gap();
         end
         phase++;
      end

      wait_for_answers(SETTLE_CYCLES);
      if (tracker.failures == 0 && tracker.pending() == 0) begin
         $display("PASS clamped_linear_table_interp_top");
      end else begin
         $display("FAIL clamped_linear_table_interp_top");
      end
      $finish;
   end

endmodule
